[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[src/mws_pkg.sv]
// Package of shared constants and types for the maximum window sum block.
`default_nettype none

package mws_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int LEN_W      = 9;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W      = (LEN_W > FILL_W) ? LEN_W : FILL_W;

    localparam logic [LEN_W-1:0]        LEN_RESET = LEN_W'(3);
    localparam logic signed [SUM_W-1:0] SUM_ERROR = SUM_W'(-1);

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_TOO_LONG = 1'b1
    } status_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       sub;
        logic                       first;
        logic                       track;
        logic                       short_seq;
    } stage_t;

endpackage

`default_nettype wire

[src/mws_if.sv]
// Stream interfaces for sample words and result words.
`default_nettype none

interface mws_sample_if;
    import mws_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface mws_result_if;
    import mws_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] max_sum;
    status_t                 status;

    modport source (output valid, output max_sum, output status, input ready);
    modport sink (input valid, input max_sum, input status, output ready);
endinterface

`default_nettype wire

[src/mws_ram.sv]
// Generic simple dual-port RAM with registered, read-first output.
`default_nettype none

module mws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/max_window_sum.sv]
// Top level: largest sliding-window sum over a sample sequence.
//
//  channel    dir  handshake       payload
//  samples    in   valid / ready   sample (s16), last
//  results    out  valid / ready   max_sum (s24), status
//  cfg        in   cfg_we          cfg_wdata = window_len (u9)
//
// One word per cycle unless a last word waits on a stalled result; a result
// passes the stage and result registers. The delay-line RAM is read and written
// in the accept cycle; the running sum updates from the registered read data.
// A stalled result register holds the stage behind it only for a last word.
// Reset clears the pointers, counters and sums; the delay line needs no clear.
`default_nettype none

`include "assert_macros.svh"

module max_window_sum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [mws_pkg::LEN_W-1:0] cfg_wdata,
    mws_sample_if.sink                samples,
    mws_result_if.source              results
);
    import mws_pkg::*;

    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        eff_len;
    logic [ADDR_W-1:0]       wp_reg;
    logic [ADDR_W-1:0]       wp_next;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [CNT_W:0]          new_fill;
    logic [CNT_W:0]          len_cmp;
    logic [ADDR_W:0]         wp_ext;
    logic [ADDR_W:0]         len_ext;
    logic [ADDR_W:0]         rd_ext;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_W-1:0]     rd_data;
    logic signed [SAMPLE_W-1:0] old_sample;

    logic                    in_fire;
    logic                    s1_valid_reg;
    stage_t                  s1_reg;
    stage_t                  s1_next;
    logic                    s1_adv;
    logic                    s1_fire;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] best_reg;
    logic signed [SUM_W-1:0] best_next;

    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    status_t                 out_status_reg;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (int'(len_reg) > MAX_WINDOW)
        begin
            eff_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign s1_adv        = !s1_reg.last || !out_valid_reg || results.ready;
    assign s1_fire       = s1_valid_reg && s1_adv;
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign in_fire       = samples.valid && samples.ready;

    // delay-line address of the word that leaves the window
    always_comb
    begin
        wp_ext  = {1'b0, wp_reg};
        len_ext = (ADDR_W + 1)'(eff_len);
        if (wp_ext >= len_ext)
        begin
            rd_ext = wp_ext - len_ext;
        end
        else
        begin
            rd_ext = wp_ext + (ADDR_W + 1)'(MAX_WINDOW) - len_ext;
        end
        rd_addr = rd_ext[ADDR_W-1:0];
    end

    always_comb
    begin
        new_fill = (CNT_W + 1)'(fill_reg) + (CNT_W + 1)'(1);
        len_cmp  = (CNT_W + 1)'(eff_len);

        if (int'(wp_reg) == MAX_WINDOW - 1)
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_reg + ADDR_W'(1);
        end

        if (int'(new_fill) > MAX_WINDOW)
        begin
            fill_next = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            fill_next = new_fill[FILL_W-1:0];
        end

        s1_next.sample    = samples.sample;
        s1_next.last      = samples.last;
        s1_next.sub       = (CNT_W + 1)'(fill_reg) >= len_cmp;
        s1_next.first     = new_fill == len_cmp;
        s1_next.track     = new_fill > len_cmp;
        s1_next.short_seq = new_fill < len_cmp;
    end

    mws_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_delay (
        .clk     (clk),
        .we      (in_fire),
        .wr_addr (wp_reg),
        .wr_data (samples.sample),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                wp_reg   <= samples.last ? '0 : wp_next;
                fill_reg <= samples.last ? '0 : fill_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg <= s1_next;
        end
    end

    assign old_sample = signed'(rd_data);

    always_comb
    begin
        sum_next = sum_reg + SUM_W'(s1_reg.sample)
                   - (s1_reg.sub ? SUM_W'(old_sample) : SUM_W'(0));
        if (s1_reg.first)
        begin
            best_next = sum_next;
        end
        else if (s1_reg.track && (sum_next > best_reg))
        begin
            best_next = sum_next;
        end
        else
        begin
            best_next = best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            best_reg <= '0;
        end
        else if (s1_fire)
        begin
            sum_reg  <= s1_reg.last ? '0 : sum_next;
            best_reg <= s1_reg.last ? '0 : best_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_reg.last)
        begin
            out_sum_reg    <= s1_reg.short_seq ? SUM_ERROR : best_next;
            out_status_reg <= s1_reg.short_seq ? STATUS_TOO_LONG : STATUS_OK;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.max_sum = out_sum_reg;
    assign results.status  = out_status_reg;

    `ASSERT_ALWAYS(a_stall_backs_up,
        !(s1_valid_reg && s1_reg.last && out_valid_reg && !results.ready) || !samples.ready,
        "input taken while a last word is blocked")
    `ASSERT_ALWAYS(a_fill_bound, int'(fill_reg) <= MAX_WINDOW, "fill count beyond depth")
    `ASSERT_NEXT(a_clear_on_last, in_fire && samples.last,
        fill_reg == '0 && wp_reg == '0, "run state not cleared after last word")

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the maximum window sum block: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import mws_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        status_t                 status;
    } result_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       typed;
        logic signed [SUM_W-1:0]    want;
        status_t                    status;
    } dir_row_t;

    localparam dir_row_t DIRECTED [24] = '{
        '{16'sd32767,  1'b1, 1'b1, SUM_ERROR,     STATUS_TOO_LONG},
        '{16'sh8000,   1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd5,      1'b1, 1'b1, SUM_ERROR,     STATUS_TOO_LONG},
        '{16'sd32767,  1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd32767,  1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd32767,  1'b1, 1'b1, 24'sd98301,    STATUS_OK},
        '{16'sh8000,   1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sh8000,   1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sh8000,   1'b1, 1'b1, -24'sd98304,   STATUS_OK},
        '{16'sd1,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{-16'sd2,     1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd3,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd100,    1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{-16'sd50,    1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd7,      1'b1, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b1, 1'b1, 24'sd0,        STATUS_OK},
        '{-16'sd1,     1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sh8000,   1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd32767,  1'b0, 1'b0, 24'sd0,        STATUS_OK},
        '{16'sd0,      1'b1, 1'b0, 24'sd0,        STATUS_OK}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    mws_sample_if smp ();
    mws_result_if res ();

    max_window_sum dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (smp),
        .results   (res)
    );

    always #5 clk = ~clk;

    // model state of the window tracker
    logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
    logic [ADDR_W-1:0]          hist_ptr = '0;
    int                         seen_cnt = 0;
    logic signed [SUM_W-1:0]    win_sum = '0;
    logic signed [SUM_W-1:0]    peak_sum = '0;
    logic [LEN_W-1:0]           win_len = LEN_RESET;

    result_t pending_results [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 37;
    int      recv_idle_pct = 69;
    logic    pressure_go;
    bit      pressure_seen = 1'b0;
    int      hold_left = 0;

    function automatic int span_of(input int len);
        if (len == 0)
            return 1;
        if (len > MAX_WINDOW)
            return MAX_WINDOW;
        return len;
    endfunction

    function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
                                       output result_t r);
        int                      span;
        int                      next_cnt;
        logic [ADDR_W-1:0]       back;
        logic signed [SUM_W-1:0] sum;
        span = span_of(int'(win_len));
        sum = win_sum + SUM_W'(s);
        if (seen_cnt >= span)
        begin
            back = hist_ptr - ADDR_W'(span);
            sum = sum - SUM_W'(hist[back]);
        end
        hist[hist_ptr] = s;
        hist_ptr = hist_ptr + ADDR_W'(1);
        win_sum = sum;
        next_cnt = seen_cnt + 1;
        if (next_cnt == span)
            peak_sum = sum;
        else if (next_cnt > span && sum > peak_sum)
            peak_sum = sum;
        seen_cnt = (next_cnt > MAX_WINDOW) ? MAX_WINDOW : next_cnt;
        r = '0;
        if (!l)
            return 1'b0;
        if (next_cnt < span)
            r = '{SUM_ERROR, STATUS_TOO_LONG};
        else
            r = '{peak_sum, STATUS_OK};
        hist_ptr = '0;
        seen_cnt = 0;
        win_sum = '0;
        peak_sum = '0;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int flavor);
        if (flavor == 0)
            return 16'sd32767;
        if (flavor == 1)
            return 16'sh8000;
        case ($urandom_range(0, 9))
            0: return 16'sd32767;
            1: return 16'sh8000;
            2: return SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch("unexpected result word, max_sum", 0, int'(res.max_sum));
            return;
        end
        want = pending_results.pop_front();
        if (res.max_sum !== want.max_sum)
            note_mismatch("max_sum", int'(want.max_sum), int'(res.max_sum));
        if (res.status !== want.status)
            note_mismatch("status", int'(want.status), int'(res.status));
    endtask

    // sink side: accept, check and stall result words
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                check_result();
            if (pressure_go && !pressure_seen)
            begin
                pressure_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[max_window_sum] ERROR");
                $finish;
            end
        end
    end

    task automatic put_word(input logic signed [SAMPLE_W-1:0] s, input logic l,
                            input logic typed, input result_t want);
        result_t r;
        bit      got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid  <= 1'b1;
        smp.sample <= s;
        smp.last   <= l;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        got = fold_sample(s, l, r);
        if (got)
            pending_results.push_back(typed ? want : r);
    endtask

    task automatic settle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_len(input int len);
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(len);
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_len = LEN_W'(len);
    endtask

    task automatic run_phase(input int len, input int s_idle, input int r_idle,
                             input int budget, input bit squeeze);
        int      sent;
        int      n;
        int      flavor;
        int      span;
        result_t none;
        settle();
        write_len(len);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        span = span_of(len);
        sent = 0;
        none = '0;
        if (squeeze)
            pressure_go <= 1'b1;
        while (sent < budget)
        begin
            if (squeeze)
                n = $urandom_range(1, 4);
            else if (sent == 0)
                n = span + $urandom_range(0, 3);
            else
                case ($urandom_range(0, 7))
                    0, 1: n = (span > 1) ? $urandom_range(1, span - 1) : 1;
                    2: n = span;
                    default: n = span + $urandom_range(0, (span < 16) ? 12 : span / 8);
                endcase
            flavor = $urandom_range(0, 9);
            for (int i = 0; i < n; i++)
                put_word(rand_sample(flavor), i == n - 1, 1'b0, none);
            sent += n;
        end
        smp.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        smp.valid   <= 1'b0;
        smp.sample  <= '0;
        smp.last    <= 1'b0;
        pressure_go <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(DIRECTED); i++)
            put_word(DIRECTED[i].sample, DIRECTED[i].last, DIRECTED[i].typed,
                     '{DIRECTED[i].want, DIRECTED[i].status});
        smp.valid <= 1'b0;

        run_phase(0,   37, 69, 150, 1'b0);
        run_phase(1,   37, 69, 130, 1'b0);
        run_phase(6,   69, 37, 230, 1'b0);
        run_phase(511, 69, 37, 262, 1'b0);
        run_phase(256, 0,  0,  262, 1'b0);
        run_phase(12,  0,  0,  160, 1'b0);
        run_phase(3,   0,  0,  80,  1'b1);

        settle();
        repeat (8) @(posedge clk);
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("[max_window_sum] OK");
        else
            $display("[max_window_sum] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/mws_pkg.sv
src/mws_if.sv
src/mws_ram.sv
src/max_window_sum.sv
test/testbench.sv
